@@ hdl/srtf_pkg.sv @@
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared widths, command codes and inter-module structs for the SRTF scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

  localparam int SLOT_W  = 2;
  localparam int BURST_W = 16;
  localparam int TIME_W  = 32;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic               load_en;
    logic [SLOT_W-1:0]  load_slot;
    logic [BURST_W-1:0] load_burst;
    logic [BURST_W-1:0] load_arrive;
    logic               commit_en;
  } cell_cmd_t;

  // Best candidate handed from one cell to the next
  typedef struct packed {
    logic               found;
    logic [BURST_W-1:0] rem;
  } cand_t;

endpackage

@@ hdl/srtf_cell.sv @@
// ----------------------------------------------------------------------------
// srtf_cell
// One task slot: remaining time, arrival tick and completion flag, plus one
// stage of the minimum-remaining-time scan chain.
// ----------------------------------------------------------------------------
module srtf_cell #(
  parameter int NUM_TASKS = 4,
  parameter int IDX       = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srtf_pkg::cell_cmd_t           cmd,
  input  logic [$clog2(NUM_TASKS)-1:0]  commit_idx,
  input  logic [srtf_pkg::TIME_W-1:0]   clock_count,
  input  logic                          cur_valid,
  input  logic [$clog2(NUM_TASKS)-1:0]  cur_slot,
  input  srtf_pkg::cand_t               cand_in,
  input  logic [$clog2(NUM_TASKS)-1:0]  cand_idx_in,
  output srtf_pkg::cand_t               cand_out,
  output logic [$clog2(NUM_TASKS)-1:0]  cand_idx_out,
  output logic                          complete_o,
  output logic                          done_nxt
);
  import srtf_pkg::*;

  localparam int IDX_W = $clog2(NUM_TASKS);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [BURST_W-1:0] rem_r, rem_nxt;
  logic [BURST_W-1:0] arrive_r, arrive_nxt;
  logic               complete_r, complete_nxt;
  cand_t              cand_r, cand_nxt;
  logic [IDX_W-1:0]   cand_idx_r, cand_idx_nxt;

  logic ready;
  logic better;
  logic load_hit;
  logic commit_hit;

  assign load_hit   = cmd.load_en && (32'(cmd.load_slot) == 32'(IDX));
  assign commit_hit = cmd.commit_en && (commit_idx == MY_IDX);

  assign ready = !complete_r && (TIME_W'(arrive_r) <= clock_count);

  // Running task wins a tie with an earlier slot; later slots need strictly less
  assign better = ready && (!cand_in.found || (rem_r < cand_in.rem) ||
                  ((rem_r == cand_in.rem) && cur_valid && (cur_slot == MY_IDX)));

  always_comb begin
    if (better) begin
      cand_nxt.found = 1'b1;
      cand_nxt.rem   = rem_r;
      cand_idx_nxt   = MY_IDX;
    end else begin
      cand_nxt     = cand_in;
      cand_idx_nxt = cand_idx_in;
    end
  end

  always_comb begin
    rem_nxt      = rem_r;
    arrive_nxt   = arrive_r;
    complete_nxt = complete_r;
    if (load_hit) begin
      rem_nxt      = cmd.load_burst;
      arrive_nxt   = cmd.load_arrive;
      complete_nxt = (cmd.load_burst == '0);
    end else if (commit_hit) begin
      rem_nxt = rem_r - BURST_W'(1);
      if (rem_r == BURST_W'(1)) begin
        complete_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r      <= '0;
      arrive_r   <= '0;
      complete_r <= 1'b1;
      cand_r     <= '0;
      cand_idx_r <= '0;
    end else begin
      rem_r      <= rem_nxt;
      arrive_r   <= arrive_nxt;
      complete_r <= complete_nxt;
      cand_r     <= cand_nxt;
      cand_idx_r <= cand_idx_nxt;
    end
  end

  assign cand_out     = cand_r;
  assign cand_idx_out = cand_idx_r;
  assign complete_o   = complete_r;
  assign done_nxt     = complete_nxt;

endmodule

@@ hdl/srtf_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// srtf_task_scheduler
// Preemptive shortest-remaining-time-first scheduler over a row of task cells.
// ----------------------------------------------------------------------------
// A load item writes one slot and produces no result. A tick item is accepted
// in the idle state; in the scan state the best candidate then ripples one cell
// per cycle down the chain of task cells, and the commit state commits the
// decrement, advances time and registers the result. The result sits in an
// output register; further loads are taken while it waits, and the next tick
// is held in its commit state until that result is taken.
module srtf_task_scheduler #(
  parameter int NUM_TASKS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_cmd,
  input  logic [srtf_pkg::SLOT_W-1:0]   in_slot,
  input  logic [srtf_pkg::BURST_W-1:0]  in_burst_len,
  input  logic [srtf_pkg::BURST_W-1:0]  in_arrive_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srtf_pkg::SLOT_W-1:0]   out_run_slot,
  output logic                          out_idle,
  output logic                          out_finished,
  output logic [srtf_pkg::TIME_W-1:0]   out_time_now,
  output logic                          out_all_done
);
  import srtf_pkg::*;

  localparam int IDX_W = $clog2(NUM_TASKS);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   cur_slot_r, cur_slot_nxt;
  logic               cur_valid_r, cur_valid_nxt;
  logic [TIME_W-1:0]  clock_r, clock_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]  run_slot_r, run_slot_nxt;
  logic               idle_r, idle_nxt;
  logic               fin_r, fin_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic               all_r, all_nxt;

  cell_cmd_t          cmd;
  cand_t              cand   [NUM_TASKS+1];
  logic [IDX_W-1:0]   cand_idx [NUM_TASKS+1];
  logic [NUM_TASKS-1:0] complete_vec;
  logic [NUM_TASKS-1:0] done_vec;

  logic accept, load, tick, out_free, commit_fire, found, fin;

  assign in_ready    = (state_r == ST_IDLE);
  assign accept      = in_valid && in_ready;
  assign load        = accept && (in_cmd == CMD_LOAD);
  assign tick        = accept && (in_cmd == CMD_TICK);
  assign out_free    = !out_valid_r || out_ready;
  assign commit_fire = (state_r == ST_COMMIT) && out_free;

  assign found = cand[NUM_TASKS].found;
  assign fin   = found && (cand[NUM_TASKS].rem == BURST_W'(1));

  assign cmd.load_en     = load;
  assign cmd.load_slot   = in_slot;
  assign cmd.load_burst  = in_burst_len;
  assign cmd.load_arrive = in_arrive_time;
  assign cmd.commit_en   = commit_fire && found;

  assign cand[0]     = '0;
  assign cand_idx[0] = '0;

  for (genvar g = 0; g < NUM_TASKS; g++) begin : g_cell
    srtf_cell #(
      .NUM_TASKS (NUM_TASKS),
      .IDX       (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .cmd          (cmd),
      .commit_idx   (cand_idx[NUM_TASKS]),
      .clock_count  (clock_r),
      .cur_valid    (cur_valid_r),
      .cur_slot     (cur_slot_r),
      .cand_in      (cand[g]),
      .cand_idx_in  (cand_idx[g]),
      .cand_out     (cand[g+1]),
      .cand_idx_out (cand_idx[g+1]),
      .complete_o   (complete_vec[g]),
      .done_nxt     (done_vec[g])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_slot_nxt  = cur_slot_r;
    cur_valid_nxt = cur_valid_r;
    clock_nxt     = clock_r;
    out_valid_nxt = out_valid_r && !out_ready;
    run_slot_nxt  = run_slot_r;
    idle_nxt      = idle_r;
    fin_nxt       = fin_r;
    time_nxt      = time_r;
    all_nxt       = all_r;

    unique case (state_r)
      ST_IDLE: begin
        if (tick) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
        // Drop the tie preference of a slot that is being reloaded
        if (load && cur_valid_r && (32'(in_slot) == 32'(cur_slot_r))) begin
          cur_valid_nxt = 1'b0;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(NUM_TASKS - 1)) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (commit_fire) begin
          state_nxt = ST_IDLE;
          if (found && !fin) begin
            cur_slot_nxt  = cand_idx[NUM_TASKS];
            cur_valid_nxt = 1'b1;
          end else begin
            cur_valid_nxt = 1'b0;
          end
          if (clock_r != '1) begin
            clock_nxt = clock_r + TIME_W'(1);
          end
          out_valid_nxt = 1'b1;
          run_slot_nxt  = found ? SLOT_W'(cand_idx[NUM_TASKS]) : '0;
          idle_nxt      = !found;
          fin_nxt       = fin;
          time_nxt      = (clock_r != '1) ? clock_r + TIME_W'(1) : clock_r;
          all_nxt       = &done_vec;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_slot_r  <= cur_slot_nxt;
      cur_valid_r <= cur_valid_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_slot_r <= run_slot_nxt;
    idle_r     <= idle_nxt;
    fin_r      <= fin_nxt;
    time_r     <= time_nxt;
    all_r      <= all_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_run_slot = run_slot_r;
  assign out_idle     = idle_r;
  assign out_finished = fin_r;
  assign out_time_now = time_r;
  assign out_all_done = all_r;

`ifndef SYNTHESIS
  a_idle_not_finished: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(idle_r && fin_r))
    else $error("idle tick reported a completion");

  a_time_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (commit_fire && (clock_r != '1)) |=> (clock_r == $past(clock_r) + TIME_W'(1)))
    else $error("time did not advance on commit");

  a_running_not_complete: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> !complete_vec[cur_slot_r])
    else $error("running task is marked complete");

  a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> ((state_r == ST_SCAN) && (cnt_r == '0)))
    else $error("tick item did not start a scan");
`endif

endmodule

@@ sim/tb_srtf_task_scheduler.sv @@
// ----------------------------------------------------------------------------
// tb_srtf_task_scheduler
// Self-checking bench for the SRTF scheduler. A short table of load and tick
// items covers idle ticks, empty loads, ties and reloads of the running slot.
// Mixed random loads and ticks follow, with random gaps on the input and stalls
// on the result side. Each result is checked against the table or an in-bench schedule.
// ----------------------------------------------------------------------------
module tb_srtf_task_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  import srtf_pkg::*;

  localparam int NUM_SLOTS    = 4;
  localparam int RANDOM_ITEMS = 1826;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 24;

  typedef struct packed {
    logic               cmd;
    logic [SLOT_W-1:0]  slot;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] arrive;
  } sched_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] run_slot;
    logic              idle;
    logic              finished;
    logic [TIME_W-1:0] time_now;
    logic              all_done;
  } sched_result_t;

  typedef struct packed {
    sched_item_t   item;
    logic          typed;
    sched_result_t res;
  } plan_row_t;

  localparam sched_result_t NO_CHECK = '0;
  localparam int PLAN_LEN = 24;

  // Time starts at 0; every tick advances it by one.
  plan_row_t plan [0:PLAN_LEN-1] = '{
    '{'{CMD_TICK, 2'd0, 16'd0, 16'd0}, 1'b1, '{2'd0, 1'b1, 1'b0, 32'd1, 1'b1}},
    '{'{CMD_LOAD, 2'd0, 16'd2, 16'd0}, 1'b0, NO_CHECK},
    '{'{CMD_LOAD, 2'd3, 16'hFFFF, 16'hFFFF}, 1'b0, NO_CHECK},
    '{'{CMD_TICK, 2'd0, 16'd0, 16'd0}, 1'b0, NO_CHECK},
    '{'{CMD_LOAD, 2'd1, 16'd1, 16'd0}, 1'b0, NO_CHECK},
    '{'{CMD_TICK, 2'd0, 16'd0, 16'd0}, 1'b1, '{2'd0, 1'b0, 1'b1, 32'd3, 1'b0}},
    '{'{CMD_TICK, 2'd0, 16'd0, 16'd0}, 1'b0, NO_CHECK},
    // empty load clears the long task out of slot 3
    '{'{CMD_LOAD, 2'd3, 16'd0, 16'd0}, 1'b0, NO_CHECK},
    '{'{CMD_TICK, 2'd0, 16'd0, 16'd0}, 1'b1, '{2'd0, 1'b1, 1'b0, 32'd5, 1'b1}},
    '{'{CMD_LOAD, 2'd2, 16'd3, 16'd0}, 1'b0, NO_CHECK},
    '{'{CMD_TICK, 2'd0, 16'd0, 16'd0}, 1'b0, NO_CHECK},
    // tie with a lower slot: running slot 2 keeps the processor
    '{'{CMD_LOAD, 2'd0, 16'd2, 16'd0}, 1'b0, NO_CHECK},
    '{'{CMD_TICK, 2'd0, 16'd0, 16'd0}, 1'b0, NO_CHECK},
    // reload the running slot: the tie now goes to the lowest slot
    '{'{CMD_LOAD, 2'd2, 16'd2, 16'd0}, 1'b0, NO_CHECK},
    '{'{CMD_TICK, 2'd0, 16'd0, 16'd0}, 1'b0, NO_CHECK},
    '{'{CMD_TICK, 2'd0, 16'd0, 16'd0}, 1'b0, NO_CHECK},
    '{'{CMD_TICK, 2'd0, 16'd0, 16'd0}, 1'b0, NO_CHECK},
    '{'{CMD_TICK, 2'd0, 16'd0, 16'd0}, 1'b0, NO_CHECK},
    // late arrival: idle until time reaches 13
    '{'{CMD_LOAD, 2'd1, 16'd2, 16'd13}, 1'b0, NO_CHECK},
    '{'{CMD_TICK, 2'd0, 16'd0, 16'd0}, 1'b0, NO_CHECK},
    '{'{CMD_TICK, 2'd0, 16'd0, 16'd0}, 1'b0, NO_CHECK},
    '{'{CMD_TICK, 2'd0, 16'd0, 16'd0}, 1'b0, NO_CHECK},
    '{'{CMD_LOAD, 2'd1, 16'd0, 16'hFFFF}, 1'b0, NO_CHECK},
    '{'{CMD_TICK, 2'd0, 16'd0, 16'd0}, 1'b1, '{2'd0, 1'b1, 1'b0, 32'd15, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_cmd;
  logic [SLOT_W-1:0]  in_slot;
  logic [BURST_W-1:0] in_burst_len;
  logic [BURST_W-1:0] in_arrive_time;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SLOT_W-1:0] out_run_slot;
  logic out_idle;
  logic out_finished;
  logic [TIME_W-1:0] out_time_now;
  logic out_all_done;

  // schedule state mirrored in the bench
  logic [BURST_W-1:0] task_rem    [0:NUM_SLOTS-1];
  logic [BURST_W-1:0] task_arrive [0:NUM_SLOTS-1];
  bit                 task_done   [0:NUM_SLOTS-1];
  int                 cur_slot;
  bit                 cur_valid;
  logic [TIME_W-1:0]  sched_now;

  sched_result_t pending_results [$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  cycles = 0;
  bit  idle_on = 1'b1;
  int  stall_left = 0;

  srtf_task_scheduler #(.NUM_TASKS(NUM_SLOTS)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_slot       (in_slot),
    .in_burst_len  (in_burst_len),
    .in_arrive_time(in_arrive_time),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_run_slot  (out_run_slot),
    .out_idle      (out_idle),
    .out_finished  (out_finished),
    .out_time_now  (out_time_now),
    .out_all_done  (out_all_done)
  );

  always #4 clk = ~clk;

  function automatic bit slot_ready(input int i);
    return !task_done[i] && ({16'd0, task_arrive[i]} <= sched_now);
  endfunction

  // Apply one item to the mirrored schedule; returns 1 when it yields a result.
  function automatic bit schedule_step(input sched_item_t it, output sched_result_t res);
    int  pick;
    bit  found;
    bit  fin;
    bit  all;
    pick  = 0;
    found = 1'b0;
    fin   = 1'b0;
    all   = 1'b1;
    res   = '0;
    if (it.cmd == CMD_LOAD) begin
      task_rem[it.slot]    = it.burst;
      task_arrive[it.slot] = it.arrive;
      task_done[it.slot]   = (it.burst == '0);
      if (cur_valid && cur_slot == int'(it.slot)) cur_valid = 1'b0;
      return 1'b0;
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_ready(i) && (!found || task_rem[i] < task_rem[pick])) begin
        pick  = i;
        found = 1'b1;
      end
    end
    // on a tie the running task keeps the processor
    if (found && cur_valid && slot_ready(cur_slot) && task_rem[cur_slot] == task_rem[pick])
      pick = cur_slot;
    if (found) begin
      task_rem[pick] = task_rem[pick] - 16'd1;
      if (task_rem[pick] == '0) begin
        task_done[pick] = 1'b1;
        cur_valid = 1'b0;
        fin = 1'b1;
      end else begin
        cur_slot  = pick;
        cur_valid = 1'b1;
      end
    end else begin
      cur_valid = 1'b0;
    end
    if (sched_now != '1) sched_now = sched_now + 32'd1;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (!task_done[i]) all = 1'b0;
    res.run_slot = found ? SLOT_W'(pick) : '0;
    res.idle     = !found;
    res.finished = fin;
    res.time_now = sched_now;
    res.all_done = all;
    return 1'b1;
  endfunction

  function automatic sched_item_t make_item();
    sched_item_t     it;
    int unsigned     kind;
    logic [32:0]     near;
    it.cmd    = ($urandom_range(0, 99) < 55) ? CMD_TICK : CMD_LOAD;
    it.slot   = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    it.burst  = BURST_W'($urandom());
    it.arrive = BURST_W'($urandom());
    if (it.cmd == CMD_LOAD) begin
      kind = $urandom_range(0, 99);
      if (kind < 8)        it.burst = '0;
      else if (kind >= 15) it.burst = BURST_W'($urandom_range(1, 12));
      // mostly arrivals close to the current time so tasks compete
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        it.arrive = '0;
      end else if (kind >= 25) begin
        near = {1'b0, sched_now} + 33'($urandom_range(0, 10));
        it.arrive = (near > 33'hFFFF) ? 16'hFFFF : near[15:0];
      end
    end
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR result %0d %s: got %0d expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(input sched_item_t it, input bit typed, input sched_result_t want);
    sched_result_t res;
    in_valid       <= 1'b1;
    in_cmd         <= it.cmd;
    in_slot        <= it.slot;
    in_burst_len   <= it.burst;
    in_arrive_time <= it.arrive;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (schedule_step(it, res))
      pending_results.push_back(typed ? want : res);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // result side: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected, time_now", out_time_now, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_run_slot !== want.run_slot)
          report_mismatch("run_slot", 32'(out_run_slot), 32'(want.run_slot));
        if (out_idle !== want.idle)
          report_mismatch("idle", 32'(out_idle), 32'(want.idle));
        if (out_finished !== want.finished)
          report_mismatch("finished", 32'(out_finished), 32'(want.finished));
        if (out_time_now !== want.time_now)
          report_mismatch("time_now", out_time_now, want.time_now);
        if (out_all_done !== want.all_done)
          report_mismatch("all_done", 32'(out_all_done), 32'(want.all_done));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = CMD_LOAD;
    in_slot        = '0;
    in_burst_len   = '0;
    in_arrive_time = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      task_rem[i]    = '0;
      task_arrive[i] = '0;
      task_done[i]   = 1'b1;
    end
    cur_slot  = 0;
    cur_valid = 1'b0;
    sched_now = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < PLAN_LEN; n++)
      send_item(plan[n].item, plan[n].typed, plan[n].res);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // quiet stretches, and none at all near the end
      idle_on = (n % 300) < 220 && n < RANDOM_ITEMS - 150;
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      send_item(make_item(), 1'b0, NO_CHECK);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/srtf_pkg.sv
hdl/srtf_cell.sv
hdl/srtf_task_scheduler.sv
sim/tb_srtf_task_scheduler.sv
